// File: rtl/bcsm_pkg.sv
package bcsm_pkg;

	// CRC-32, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// signature table
	localparam int unsigned SIG_COUNT = 8;
	localparam int unsigned SIG_IDX_W = $clog2(SIG_COUNT);
	localparam int unsigned CFG_IDX_W = SIG_IDX_W + 1;
	localparam logic [31:0] SIG_UNKNOWN = 32'hFFFF_FFFF;

	typedef logic [31:0] sig_t;
	typedef sig_t [SIG_COUNT-1:0] sig_tab_t;

	localparam sig_tab_t SIG_RESET = '{
		7: 32'hFFFF_FFFF,
		6: 32'hACC8_580A,
		5: 32'h98BC_2C86,
		4: 32'h0B05_0EE0,
		3: 32'hFFFF_FFFF,
		2: 32'hFFFF_FFFF,
		1: 32'h90BB_6CB5,
		0: 32'h6170_A4A1
	};

	// fold one byte into the running CRC, one bit per step (pure XOR network)
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'h0, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/bcsm_byte_if.sv
interface bcsm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/bcsm_result_if.sv
interface bcsm_result_if;
	logic                                valid;
	logic                                ready;
	logic [31:0]                         crc_value;
	logic                                found;
	logic [bcsm_pkg::SIG_IDX_W-1:0]      entry_index;

	modport source (output valid, output crc_value, output found, output entry_index, input ready);
	modport sink (input valid, input crc_value, input found, input entry_index, output ready);
endinterface

// File: rtl/bootcode_crc32_signature_match.sv
// Boot code CRC-32 matcher. Bytes arrive on the stream channel, one per beat, and are
// folded into a reflected CRC-32 (poly 0xEDB88320, init all ones, final inversion).
// The beat flagged last_byte yields one result beat: the finished CRC, a found flag and
// the lowest index of the eight signature registers that equals it (0 if none); a
// signature of all ones never matches. Other beats yield nothing. Each byte lands in an
// input register; from there the byte-wide CRC update plus the eight parallel compares
// feed the running CRC register and, for the last byte, the registered result. A byte is
// accepted every cycle unless the stream stalls, and the stream stalls only while a result
// waits to be taken and another last byte is queued behind it. Signatures are written
// through cfg_we/cfg_idx/cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce; indexes above 7 are ignored.
module bootcode_crc32_signature_match (
	input  logic                              clk,
	input  logic                              arst_n,
	bcsm_byte_if.sink                         stream,
	bcsm_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [bcsm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [31:0]                       cfg_wdata
);

	logic                              valid_s1;
	logic [7:0]                        data_s1;
	logic                              last_s1;
	logic                              adv_s1;
	logic [31:0]                       crc_q;
	logic [31:0]                       crc_next;
	logic [31:0]                       finished;
	bcsm_pkg::sig_tab_t                sig_q;
	logic [bcsm_pkg::SIG_COUNT-1:0]    hit;
	logic                              any_hit;
	logic [bcsm_pkg::SIG_IDX_W-1:0]    hit_idx;
	logic                              out_valid_q;
	logic [31:0]                       out_crc_q;
	logic                              out_found_q;
	logic [bcsm_pkg::SIG_IDX_W-1:0]    out_idx_q;

	// stage 1 moves on unless a last byte meets a full result register
	assign adv_s1       = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign stream.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_s1 <= stream.data_byte;
			last_s1 <= stream.last_byte;
		end
	end

	// CRC update and signature compare
	assign crc_next = bcsm_pkg::crc_byte(crc_q, data_s1);
	assign finished = ~crc_next;

	always_comb begin
		for (int i = 0; i < bcsm_pkg::SIG_COUNT; i++) begin
			hit[i] = (sig_q[i] != bcsm_pkg::SIG_UNKNOWN) && (sig_q[i] == finished);
		end
	end

	// lowest set hit wins
	always_comb begin
		hit_idx = '0;
		for (int i = bcsm_pkg::SIG_COUNT - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = i[bcsm_pkg::SIG_IDX_W-1:0];
			end
		end
	end
	assign any_hit = |hit;

	// running CRC, back to all ones after each run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= bcsm_pkg::CRC_INIT;
		end else if (adv_s1) begin
			crc_q <= last_s1 ? bcsm_pkg::CRC_INIT : crc_next;
		end
	end

	// signature registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q <= bcsm_pkg::SIG_RESET;
		end else if (cfg_we && (cfg_idx < bcsm_pkg::CFG_IDX_W'(bcsm_pkg::SIG_COUNT))) begin
			sig_q[cfg_idx[bcsm_pkg::SIG_IDX_W-1:0]] <= cfg_wdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_crc_q   <= finished;
			out_found_q <= any_hit;
			out_idx_q   <= hit_idx;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.crc_value   = out_crc_q;
	assign result.found       = out_found_q;
	assign result.entry_index = out_idx_q;

endmodule

// File: rtl/bcsm_checker.sv
module bcsm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [31:0]                       out_crc,
	input logic                              out_found,
	input logic [bcsm_pkg::SIG_IDX_W-1:0]    out_idx
);

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_crc) && $stable(out_found)
			&& $stable(out_idx))
		else $error("result beat changed while stalled");

	// the byte stream only stalls behind a waiting result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("stream stalled with result side free");

	// no match reports index zero
	a_miss_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_idx == '0)
		else $error("entry index nonzero on a miss");

	// an all-ones CRC can only match an unknown entry, which never matches
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_found |-> out_crc != bcsm_pkg::SIG_UNKNOWN)
		else $error("match reported on the unknown signature value");

endmodule

bind bootcode_crc32_signature_match bcsm_checker u_bcsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (stream.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_crc   (result.crc_value),
	.out_found (result.found),
	.out_idx   (result.entry_index)
);
